// ----- hdl/pool_forward_max_avg_core_defines.svh -----
// ---------------------------------------------------------------------------
// Pooling core assertion macros
// Shared assertion forms; they expect clk and rst to be visible where used.
// ---------------------------------------------------------------------------
`ifndef POOL_FORWARD_MAX_AVG_CORE_DEFINES_SVH
`define POOL_FORWARD_MAX_AVG_CORE_DEFINES_SVH

// Consequent checked in the same cycle as the antecedent.
`define PFMA_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Consequent checked in the cycle after the antecedent.
`define PFMA_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- hdl/pfma_pkg.sv -----
// ---------------------------------------------------------------------------
// Pooling core package
// Register map, reset values, default sizes and controller interface types.
// ---------------------------------------------------------------------------
package pfma_pkg;

  localparam int DEF_MAX_OUT_WIDTH = 64;
  localparam int DEF_MAX_KERNEL    = 8;
  localparam int DEF_SAMPLE_BITS   = 16;

  localparam int CFG_INDEX_BITS  = 2;
  localparam int CFG_DATA_BITS   = 7;
  localparam int KERNEL_CFG_BITS = 4;
  localparam int WIDTH_CFG_BITS  = 7;
  localparam int OFFSET_BITS     = 6;

  localparam logic [CFG_INDEX_BITS-1:0] CFG_POOL_MODE  = 2'd0;
  localparam logic [CFG_INDEX_BITS-1:0] CFG_KERNEL_DIM = 2'd1;
  localparam logic [CFG_INDEX_BITS-1:0] CFG_OUT_WIDTH  = 2'd2;

  localparam logic MODE_MAX = 1'b0;
  localparam logic MODE_AVG = 1'b1;

  localparam logic                       POOL_MODE_RESET  = MODE_MAX;
  localparam logic [KERNEL_CFG_BITS-1:0] KERNEL_DIM_RESET = 4'd2;
  localparam logic [WIDTH_CFG_BITS-1:0]  OUT_WIDTH_RESET  = 7'd14;

  typedef struct packed {
    logic accept;
    logic update;
    logic div_start;
    logic load;
  } pfma_cmd_t;

  typedef struct packed {
    logic window_end;
    logic avg_mode;
    logic div_done;
    logic result_free;
  } pfma_status_t;

endpackage

// ----- hdl/pfma_ram.sv -----
// ---------------------------------------------------------------------------
// Generic single-port-write RAM
// One write port and one read port with registered read data.
// ---------------------------------------------------------------------------
module pfma_ram #(
  parameter int WIDTH     = 8,
  parameter int DEPTH     = 64,
  parameter int ADDR_BITS = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic                 clk,
  input  logic                 we,
  input  logic [ADDR_BITS-1:0] waddr,
  input  logic [WIDTH-1:0]     wdata,
  input  logic                 re,
  input  logic [ADDR_BITS-1:0] raddr,
  output logic [WIDTH-1:0]     rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ----- hdl/pfma_div.sv -----
// ---------------------------------------------------------------------------
// Pooling core divider
// Unsigned restoring divider producing one quotient bit per cycle.
// ---------------------------------------------------------------------------
module pfma_div #(
  parameter int DIVIDEND_BITS = 22,
  parameter int DIVISOR_BITS  = 8
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     start,
  input  logic [DIVIDEND_BITS-1:0] dividend,
  input  logic [DIVISOR_BITS-1:0]  divisor,
  output logic [DIVIDEND_BITS-1:0] quotient,
  output logic                     busy,
  output logic                     done
);

  localparam int CNT_BITS = $clog2(DIVIDEND_BITS + 1);
  localparam logic [CNT_BITS-1:0] LAST_COUNT = CNT_BITS'(DIVIDEND_BITS);

  logic [CNT_BITS-1:0]     count;
  logic [DIVISOR_BITS-1:0] dvs;
  logic [DIVISOR_BITS-1:0] rem;
  logic [DIVISOR_BITS:0]   rem_shift;
  logic [DIVISOR_BITS:0]   rem_diff;
  logic                    fits;

  assign done      = busy && (count == LAST_COUNT);
  assign rem_shift = {rem, quotient[DIVIDEND_BITS-1]};
  assign rem_diff  = rem_shift - {1'b0, dvs};
  assign fits      = (rem_shift >= {1'b0, dvs});

  always_ff @(posedge clk) begin
    if (rst) begin
      busy  <= 1'b0;
      count <= '0;
    end else if (start) begin
      busy  <= 1'b1;
      count <= '0;
    end else if (done) begin
      busy <= 1'b0;
    end else if (busy) begin
      count <= count + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      quotient <= dividend;
      rem      <= '0;
      dvs      <= divisor;
    end else if (busy && !done) begin
      quotient <= {quotient[DIVIDEND_BITS-2:0], fits};
      rem      <= fits ? rem_diff[DIVISOR_BITS-1:0] : rem_shift[DIVISOR_BITS-1:0];
    end
  end

endmodule

// ----- hdl/pfma_datapath.sv -----
// ---------------------------------------------------------------------------
// Pooling core datapath
// Configuration registers, map position counters, the per-column window
// store, the update arithmetic, the divider and the result register.
// ---------------------------------------------------------------------------
`include "pool_forward_max_avg_core_defines.svh"

module pfma_datapath #(
  parameter int MAX_OUT_WIDTH = pfma_pkg::DEF_MAX_OUT_WIDTH,
  parameter int MAX_KERNEL    = pfma_pkg::DEF_MAX_KERNEL,
  parameter int SAMPLE_BITS   = pfma_pkg::DEF_SAMPLE_BITS
) (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  cfg_we,
  input  logic [pfma_pkg::CFG_INDEX_BITS-1:0]   cfg_index,
  input  logic [pfma_pkg::CFG_DATA_BITS-1:0]    cfg_data,
  input  logic signed [SAMPLE_BITS-1:0]         pixel,
  input  pfma_pkg::pfma_cmd_t                   cmd,
  output pfma_pkg::pfma_status_t                status,
  input  logic                                  result_stall,
  output logic                                  result_valid,
  output logic signed [SAMPLE_BITS-1:0]         pooled_value,
  output logic [pfma_pkg::OFFSET_BITS-1:0]      argmax_index,
  output logic                                  last_in_map
);

  import pfma_pkg::*;

  localparam int KB       = $clog2(MAX_KERNEL + 1);
  localparam int XB       = (MAX_KERNEL > 1) ? $clog2(MAX_KERNEL) : 1;
  localparam int WB       = $clog2(MAX_OUT_WIDTH + 1);
  localparam int WXB      = (MAX_OUT_WIDTH > 1) ? $clog2(MAX_OUT_WIDTH) : 1;
  localparam int ACC_BITS = SAMPLE_BITS + 2 * XB;
  localparam int DIVB     = 2 * KB;
  localparam int OFFB     = XB + KB;
  localparam int RAM_BITS = ACC_BITS + OFFSET_BITS;

  logic                       pool_mode;
  logic [KERNEL_CFG_BITS-1:0] kernel_dim;
  logic [WIDTH_CFG_BITS-1:0]  out_width;

  logic [KB-1:0]   eff_k;
  logic [WB-1:0]   eff_w;
  logic [KB-1:0]   k_last;
  logic [WB-1:0]   w_last;
  logic [DIVB-1:0] kk;

  logic [XB-1:0]  x;
  logic [XB-1:0]  y;
  logic [WXB-1:0] wx;
  logic [WXB-1:0] wy;
  logic           x_end;
  logic           y_end;
  logic           wx_end;
  logic           wy_end;
  logic           cfg_hit;
  logic [OFFB-1:0] off_full;

  logic signed [SAMPLE_BITS-1:0] px_hold;
  logic [WXB-1:0]                wx_hold;
  logic [OFFSET_BITS-1:0]        off_hold;
  logic                          first_hold;
  logic                          wend_hold;
  logic                          last_hold;

  logic [RAM_BITS-1:0]        rdata;
  logic signed [ACC_BITS-1:0] px_ext;
  logic signed [ACC_BITS-1:0] old_acc;
  logic [OFFSET_BITS-1:0]     old_off;
  logic signed [ACC_BITS-1:0] acc_new;
  logic [OFFSET_BITS-1:0]     off_new;
  logic [ACC_BITS-1:0]        acc_mag;

  logic signed [ACC_BITS-1:0] acc_res;
  logic [OFFSET_BITS-1:0]     off_res;
  logic                       neg_res;
  logic [ACC_BITS-1:0]        quotient;
  logic [ACC_BITS-1:0]        avg_full;
  logic                       div_busy;
  logic                       div_done;

  always_comb begin
    if (kernel_dim == '0) begin
      eff_k = KB'(1);
    end else if ({4'b0, kernel_dim} > 8'(MAX_KERNEL)) begin
      eff_k = KB'(MAX_KERNEL);
    end else begin
      eff_k = KB'(kernel_dim);
    end
    if (out_width == '0) begin
      eff_w = WB'(1);
    end else if ({2'b0, out_width} > 9'(MAX_OUT_WIDTH)) begin
      eff_w = WB'(MAX_OUT_WIDTH);
    end else begin
      eff_w = WB'(out_width);
    end
  end

  assign k_last = eff_k - 1'b1;
  assign w_last = eff_w - 1'b1;
  assign kk     = DIVB'(eff_k) * DIVB'(eff_k);

  assign x_end  = (x == XB'(k_last));
  assign y_end  = (y == XB'(k_last));
  assign wx_end = (wx == WXB'(w_last));
  assign wy_end = (wy == WXB'(w_last));

  assign cfg_hit  = (cfg_index == CFG_POOL_MODE) || (cfg_index == CFG_KERNEL_DIM) ||
                    (cfg_index == CFG_OUT_WIDTH);
  assign off_full = OFFB'(y) * OFFB'(eff_k) + OFFB'(x);

  always_ff @(posedge clk) begin
    if (rst) begin
      pool_mode  <= POOL_MODE_RESET;
      kernel_dim <= KERNEL_DIM_RESET;
      out_width  <= OUT_WIDTH_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_POOL_MODE:  pool_mode  <= cfg_data[0];
        CFG_KERNEL_DIM: kernel_dim <= cfg_data[KERNEL_CFG_BITS-1:0];
        CFG_OUT_WIDTH:  out_width  <= cfg_data[WIDTH_CFG_BITS-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst || (cfg_we && cfg_hit)) begin
      x  <= '0;
      y  <= '0;
      wx <= '0;
      wy <= '0;
    end else if (cmd.accept) begin
      if (!x_end) begin
        x <= x + 1'b1;
      end else begin
        x <= '0;
        if (!wx_end) begin
          wx <= wx + 1'b1;
        end else begin
          wx <= '0;
          if (!y_end) begin
            y <= y + 1'b1;
          end else begin
            y  <= '0;
            wy <= wy_end ? '0 : wy + 1'b1;
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      px_hold    <= pixel;
      wx_hold    <= wx;
      off_hold   <= OFFSET_BITS'(off_full);
      first_hold <= (x == '0) && (y == '0);
      wend_hold  <= x_end && y_end;
      last_hold  <= x_end && wx_end && y_end && wy_end;
    end
  end

  pfma_ram #(
    .WIDTH (RAM_BITS),
    .DEPTH (MAX_OUT_WIDTH)
  ) u_window_ram (
    .clk   (clk),
    .we    (cmd.update),
    .waddr (wx_hold),
    .wdata ({off_new, acc_new}),
    .re    (cmd.accept),
    .raddr (wx),
    .rdata (rdata)
  );

  always_comb begin
    px_ext  = {{(ACC_BITS - SAMPLE_BITS){px_hold[SAMPLE_BITS-1]}}, px_hold};
    old_acc = first_hold ? '0 : $signed(rdata[ACC_BITS-1:0]);
    old_off = first_hold ? '0 : rdata[RAM_BITS-1:ACC_BITS];
    acc_new = old_acc;
    off_new = old_off;
    if (pool_mode == MODE_AVG) begin
      acc_new = old_acc + px_ext;
    end else if (px_ext > old_acc) begin
      acc_new = px_ext;
      off_new = off_hold;
    end
    acc_mag = acc_new[ACC_BITS-1] ? ACC_BITS'(-acc_new) : ACC_BITS'(acc_new);
  end

  always_ff @(posedge clk) begin
    if (cmd.update) begin
      acc_res <= acc_new;
      off_res <= off_new;
      neg_res <= acc_new[ACC_BITS-1];
    end
  end

  pfma_div #(
    .DIVIDEND_BITS (ACC_BITS),
    .DIVISOR_BITS  (DIVB)
  ) u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (cmd.div_start),
    .dividend (acc_mag),
    .divisor  (kk),
    .quotient (quotient),
    .busy     (div_busy),
    .done     (div_done)
  );

  assign avg_full = neg_res ? (~quotient + 1'b1) : quotient;

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (cmd.load) begin
      result_valid <= 1'b1;
    end else if (result_valid && !result_stall) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      if (pool_mode == MODE_AVG) begin
        pooled_value <= $signed(avg_full[SAMPLE_BITS-1:0]);
        argmax_index <= '0;
      end else begin
        pooled_value <= acc_res[SAMPLE_BITS-1:0];
        argmax_index <= off_res;
      end
      last_in_map <= last_hold;
    end
  end

  assign status.window_end  = wend_hold;
  assign status.avg_mode    = (pool_mode == MODE_AVG);
  assign status.div_done    = div_done;
  assign status.result_free = !result_valid || !result_stall;

  `PFMA_ASSERT_NOW(a_update_div_idle, cmd.update, !div_busy, "Window update while dividing")
  `PFMA_ASSERT_NEXT(a_avg_no_index, cmd.load && (pool_mode == MODE_AVG), argmax_index == '0, "Average result carries an argmax offset")

endmodule

// ----- hdl/pfma_ctrl.sv -----
// ---------------------------------------------------------------------------
// Pooling core controller
// Sequences accept/update per word, avg division and result load per window.
// ---------------------------------------------------------------------------
`include "pool_forward_max_avg_core_defines.svh"

module pfma_ctrl (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   pixel_valid,
  output logic                   pixel_stall,
  output logic                   cfg_ready,
  input  pfma_pkg::pfma_status_t status,
  output pfma_pkg::pfma_cmd_t    cmd
);

  import pfma_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_CALC = 4'b0010,
    S_DIV  = 4'b0100,
    S_EMIT = 4'b1000
  } state_t;

  state_t state;
  state_t state_next;

  assign pixel_stall   = (state != S_IDLE);
  assign cfg_ready     = (state == S_IDLE) && !pixel_valid;
  assign cmd.accept    = (state == S_IDLE) && pixel_valid;
  assign cmd.update    = (state == S_CALC);
  assign cmd.div_start = (state == S_CALC) && status.window_end && status.avg_mode;
  assign cmd.load      = (state == S_EMIT) && status.result_free;

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (pixel_valid) begin
          state_next = S_CALC;
        end
      end
      S_CALC: begin
        if (!status.window_end) begin
          state_next = S_IDLE;
        end else if (status.avg_mode) begin
          state_next = S_DIV;
        end else begin
          state_next = S_EMIT;
        end
      end
      S_DIV: begin
        if (status.div_done) begin
          state_next = S_EMIT;
        end
      end
      S_EMIT: begin
        if (status.result_free) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  `PFMA_ASSERT_NOW(a_calc_after_accept, state == S_CALC, $past(cmd.accept), "Update without an accepted word")
  `PFMA_ASSERT_NEXT(a_div_to_emit, (state == S_DIV) && status.div_done, state == S_EMIT, "Quotient not taken to the result")

endmodule

// ----- hdl/pool_forward_max_avg_core.sv -----
// ---------------------------------------------------------------------------
// Max / average pooling core
// Non-overlapping square-window pooling over a raster stream of Q8.8 samples.
// ---------------------------------------------------------------------------
// A pixel word is first accepted, which issues the read of its window column
// from the window RAM, and then updated, which writes that entry back. The
// pixel that closes a window then goes to the result load in max mode, and
// in average mode first through the bit-serial divider, which produces one
// quotient bit per cycle; the result load waits only while the previous
// result is still stalled. Configuration writes are taken while no pixel is
// being processed; mapped writes restart the map at its first sample.
module pool_forward_max_avg_core #(
  parameter int MAX_OUT_WIDTH = pfma_pkg::DEF_MAX_OUT_WIDTH,
  parameter int MAX_KERNEL    = pfma_pkg::DEF_MAX_KERNEL,
  parameter int SAMPLE_BITS   = pfma_pkg::DEF_SAMPLE_BITS
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [pfma_pkg::CFG_INDEX_BITS-1:0] cfg_index,
  input  logic [pfma_pkg::CFG_DATA_BITS-1:0]  cfg_data,
  input  logic                                pixel_valid,
  output logic                                pixel_stall,
  input  logic signed [SAMPLE_BITS-1:0]       pixel,
  output logic                                result_valid,
  input  logic                                result_stall,
  output logic signed [SAMPLE_BITS-1:0]       pooled_value,
  output logic [pfma_pkg::OFFSET_BITS-1:0]    argmax_index,
  output logic                                last_in_map
);

  import pfma_pkg::*;

  pfma_cmd_t    cmd;
  pfma_status_t status;

  pfma_ctrl u_ctrl (
    .clk         (clk),
    .rst         (rst),
    .pixel_valid (pixel_valid),
    .pixel_stall (pixel_stall),
    .cfg_ready   (cfg_ready),
    .status      (status),
    .cmd         (cmd)
  );

  pfma_datapath #(
    .MAX_OUT_WIDTH (MAX_OUT_WIDTH),
    .MAX_KERNEL    (MAX_KERNEL),
    .SAMPLE_BITS   (SAMPLE_BITS)
  ) u_datapath (
    .clk          (clk),
    .rst          (rst),
    .cfg_we       (cfg_valid && cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .pixel        (pixel),
    .cmd          (cmd),
    .status       (status),
    .result_stall (result_stall),
    .result_valid (result_valid),
    .pooled_value (pooled_value),
    .argmax_index (argmax_index),
    .last_in_map  (last_in_map)
  );

endmodule
